@@ sv/rpq_pkg.sv @@
package rpq_pkg;

  localparam int BUFFER_BYTES  = 4096;
  localparam int MAX_PACKETS   = 1024;
  localparam int RESEND_PERIOD = 128;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int IDX_W  = $clog2(MAX_PACKETS);
  localparam int RC_W   = (RESEND_PERIOD > 1) ? $clog2(RESEND_PERIOD) : 1;
  localparam int CNT_W  = ADDR_W + 1;

  localparam logic [7:0] FLAG_SINGLE   = 8'h01;
  localparam logic [7:0] FLAG_MODIFIED = 8'h02;

  typedef enum logic [2:0] {
    OP_ADD_START   = 3'd0,
    OP_ADD_BYTE    = 3'd1,
    OP_SEND_STREAM = 3'd2,
    OP_SEND_OLDEST = 3'd3,
    OP_SEND_RESEND = 3'd4,
    OP_ACK         = 3'd5,
    OP_CLEAR       = 3'd6,
    OP_READ_BYTE   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_CHK,
    S_WAIT,
    S_SETTLE,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] pos;
    logic [15:0]       number;
    logic [ADDR_W-1:0] size;
    logic [7:0]        flags;
  } desc_t;

  typedef struct packed {
    logic init;
    logic accept;
    logic exec;
    logic chk;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic stream;
    logic more;
    logic out_free;
  } sts_t;

endpackage

@@ sv/rpq_ctrl.sv @@
module rpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rpq_pkg::sts_t sts_i,
  output logic          in_stall_o,
  output rpq_pkg::cmd_t cmd_o
);

  rpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpq_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpq_pkg::S_INIT:   state_d = rpq_pkg::S_IDLE;
      rpq_pkg::S_IDLE:   if (in_valid_i) state_d = rpq_pkg::S_LOAD;
      rpq_pkg::S_LOAD:   state_d = rpq_pkg::S_EXEC;
      rpq_pkg::S_EXEC:   state_d = sts_i.stream ? rpq_pkg::S_CHK : rpq_pkg::S_SETTLE;
      rpq_pkg::S_CHK:    state_d = sts_i.more ? rpq_pkg::S_WAIT : rpq_pkg::S_SETTLE;
      rpq_pkg::S_WAIT:   state_d = rpq_pkg::S_CHK;
      rpq_pkg::S_SETTLE: state_d = rpq_pkg::S_FIN;
      rpq_pkg::S_FIN:    if (sts_i.out_free) state_d = rpq_pkg::S_IDLE;
      default:           state_d = rpq_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      rpq_pkg::S_INIT: cmd_o.init = 1'b1;
      rpq_pkg::S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      rpq_pkg::S_EXEC: cmd_o.exec = 1'b1;
      rpq_pkg::S_CHK:  cmd_o.chk = 1'b1;
      rpq_pkg::S_FIN:  cmd_o.fin = sts_i.out_free;
      default: ;
    endcase
  end

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.init, cmd_o.accept, cmd_o.exec, cmd_o.chk, cmd_o.fin}))
    else $error("more than one command at once");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == rpq_pkg::S_LOAD)
    else $error("accept did not start an item");
  a_wait_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rpq_pkg::S_WAIT |=> cmd_o.chk)
    else $error("wait not followed by check");

endmodule

@@ sv/rpq_dp.sv @@
module rpq_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rpq_pkg::cmd_t cmd_i,
  output rpq_pkg::sts_t sts_o,
  input  logic [2:0]    operation_i,
  input  logic [7:0]    data_byte_i,
  input  logic [11:0]   packet_size_i,
  input  logic [15:0]   packet_number_i,
  input  logic [7:0]    packet_flags_i,
  input  logic [12:0]   link_space_i,
  input  logic [11:0]   read_address_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic          accepted_o,
  output logic [11:0]   tx_start_o,
  output logic [12:0]   tx_count_o,
  output logic [7:0]    read_data_o,
  output logic          queue_empty_o,
  output logic [15:0]   oldest_number_o
);

  localparam int AW = rpq_pkg::ADDR_W;
  localparam int IW = rpq_pkg::IDX_W;
  localparam int CW = rpq_pkg::CNT_W;
  localparam int RW = rpq_pkg::RC_W;

  rpq_pkg::desc_t desc_mem [rpq_pkg::MAX_PACKETS];
  logic [7:0]     byte_mem [rpq_pkg::BUFFER_BYTES];

  rpq_pkg::op_e   op_q;
  logic [7:0]     dbyte_q, pflags_q;
  logic [AW-1:0]  psize_q, raddr_q;
  logic [15:0]    pnum_q;
  logic [CW-1:0]  space_q;

  rpq_pkg::desc_t rd_old_q, rd_new_q;
  logic [7:0]     byte_rd_q;

  logic [IW-1:0]  oldest_q, oldest_d, newest_q, newest_d;
  logic [RW-1:0]  rc_q, rc_d;
  logic [AW-1:0]  fptr_q, fptr_d;
  logic [CW-1:0]  frem_q, frem_d, left_q, left_d;

  logic           acc_q, acc_d;
  logic [AW-1:0]  txs_q, txs_d;
  logic [CW-1:0]  txc_q, txc_d;
  logic [7:0]     rdata_q, rdata_d;

  logic           out_valid_q;
  logic           oacc_q, oempty_q;
  logic [AW-1:0]  otxs_q;
  logic [CW-1:0]  otxc_q;
  logic [7:0]     ordata_q;
  logic [15:0]    onum_q;

  logic           desc_we, byte_we, more;
  logic [IW-1:0]  desc_waddr;
  rpq_pkg::desc_t desc_wdata;

  logic           nonempty, ring_full, fit, single;
  logic [AW-1:0]  start, room;
  logic [IW-1:0]  nxt_new;
  logic [CW-1:0]  total, sent, old_size;
  logic [RW-1:0]  rc_inc;

  assign nonempty  = rd_old_q.size != '0;
  assign start     = rd_new_q.pos + rd_new_q.size;
  assign room      = rd_old_q.pos - start;
  assign nxt_new   = newest_q + IW'(1);
  assign ring_full = nonempty && (nxt_new == oldest_q);
  assign old_size  = {1'b0, rd_old_q.size};
  assign total     = {1'b0, rd_new_q.pos - rd_old_q.pos} + {1'b0, rd_new_q.size};
  assign sent      = (space_q < total) ? space_q : total;
  assign fit       = space_q >= old_size;
  assign single    = (rd_old_q.flags & rpq_pkg::FLAG_SINGLE) != '0;
  assign rc_inc    = (rc_q == RW'(rpq_pkg::RESEND_PERIOD - 1)) ? '0 : rc_q + RW'(1);

  always_comb begin
    oldest_d   = oldest_q;
    newest_d   = newest_q;
    rc_d       = rc_q;
    fptr_d     = fptr_q;
    frem_d     = frem_q;
    left_d     = left_q;
    acc_d      = acc_q;
    txs_d      = txs_q;
    txc_d      = txc_q;
    rdata_d    = rdata_q;
    desc_we    = 1'b0;
    desc_waddr = oldest_q;
    desc_wdata = '0;
    byte_we    = 1'b0;
    more       = 1'b0;

    if (cmd_i.init) begin
      desc_we    = 1'b1;
      desc_waddr = '0;
    end

    if (cmd_i.exec) begin
      acc_d   = 1'b0;
      txs_d   = '0;
      txc_d   = '0;
      rdata_d = '0;
      left_d  = '0;
      unique case (op_q)
        rpq_pkg::OP_ADD_START: begin
          if (psize_q != '0 && !ring_full && (!nonempty || room >= psize_q)) begin
            desc_we    = 1'b1;
            desc_waddr = nonempty ? nxt_new : newest_q;
            desc_wdata = '{pos: start, number: pnum_q, size: psize_q, flags: pflags_q};
            newest_d   = desc_waddr;
            fptr_d     = start;
            frem_d     = {1'b0, psize_q};
            acc_d      = 1'b1;
          end
        end
        rpq_pkg::OP_ADD_BYTE: begin
          if (frem_q != '0) begin
            byte_we = 1'b1;
            fptr_d  = fptr_q + AW'(1);
            frem_d  = frem_q - CW'(1);
          end
        end
        rpq_pkg::OP_SEND_STREAM: begin
          if (nonempty) begin
            txs_d  = rd_old_q.pos;
            txc_d  = sent;
            acc_d  = sent != '0;
            left_d = sent;
          end
        end
        rpq_pkg::OP_SEND_OLDEST: begin
          if (nonempty && fit) begin
            acc_d   = 1'b1;
            txs_d   = rd_old_q.pos;
            txc_d   = old_size;
            desc_we = 1'b1;
            if (oldest_q != newest_q) oldest_d = oldest_q + IW'(1);
            rc_d    = '0;
          end
        end
        rpq_pkg::OP_SEND_RESEND: begin
          rc_d = rc_inc;
          if (nonempty && (rc_q == '0 || single) && fit) begin
            acc_d = 1'b1;
            txs_d = rd_old_q.pos;
            txc_d = old_size;
            if (single) begin
              desc_we = 1'b1;
              if (oldest_q != newest_q) oldest_d = oldest_q + IW'(1);
              rc_d    = '0;
            end
          end
        end
        rpq_pkg::OP_ACK: begin
          if (rd_old_q.number == pnum_q) begin
            desc_we = 1'b1;
            if (oldest_q != newest_q) oldest_d = oldest_q + IW'(1);
            rc_d    = '0;
          end
        end
        rpq_pkg::OP_CLEAR: begin
          desc_we    = 1'b1;
          desc_waddr = '0;
          oldest_d   = '0;
          newest_d   = '0;
          rc_d       = '0;
          frem_d     = '0;
        end
        rpq_pkg::OP_READ_BYTE: rdata_d = byte_rd_q;
        default: ;
      endcase
    end

    if (cmd_i.chk && left_q != '0) begin
      if (nonempty && old_size <= left_q) begin
        left_d  = left_q - old_size;
        desc_we = 1'b1;
        if (oldest_q != newest_q) oldest_d = oldest_q + IW'(1);
        rc_d    = '0;
        more    = 1'b1;
      end else begin
        desc_we    = 1'b1;
        desc_wdata = '{pos:    rd_old_q.pos + left_q[AW-1:0],
                       number: rd_old_q.number,
                       size:   rd_old_q.size - left_q[AW-1:0],
                       flags:  rd_old_q.flags | rpq_pkg::FLAG_MODIFIED};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_we) desc_mem[desc_waddr] <= desc_wdata;
    rd_old_q <= desc_mem[oldest_q];
    rd_new_q <= desc_mem[newest_q];
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[fptr_q] <= dbyte_q;
    byte_rd_q <= byte_mem[raddr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= rpq_pkg::op_e'(operation_i);
      dbyte_q  <= data_byte_i;
      psize_q  <= packet_size_i;
      pnum_q   <= packet_number_i;
      pflags_q <= packet_flags_i;
      space_q  <= link_space_i;
      raddr_q  <= read_address_i;
    end
    left_q  <= left_d;
    acc_q   <= acc_d;
    txs_q   <= txs_d;
    txc_q   <= txc_d;
    rdata_q <= rdata_d;
    if (cmd_i.fin) begin
      oacc_q   <= acc_q;
      otxs_q   <= txs_q;
      otxc_q   <= txc_q;
      ordata_q <= rdata_q;
      oempty_q <= rd_old_q.size == '0;
      onum_q   <= rd_old_q.number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      newest_q    <= '0;
      rc_q        <= '0;
      fptr_q      <= '0;
      frem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      rc_q     <= rc_d;
      fptr_q   <= fptr_d;
      frem_q   <= frem_d;
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.stream   = cmd_i.exec && op_q == rpq_pkg::OP_SEND_STREAM && nonempty;
  assign sts_o.more     = more;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = oacc_q;
  assign tx_start_o      = otxs_q;
  assign tx_count_o      = otxc_q;
  assign read_data_o     = ordata_q;
  assign queue_empty_o   = oempty_q;
  assign oldest_number_o = onum_q;

  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_we |-> (cmd_i.init || cmd_i.exec || cmd_i.chk))
    else $error("descriptor write outside a work phase");
  a_empty_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && rd_old_q.size == '0) |-> oldest_q == newest_q)
    else $error("empty queue with distinct indices");
  a_frem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frem_q < CW'(rpq_pkg::BUFFER_BYTES))
    else $error("fill count out of range");

endmodule

@@ sv/retransmit_packet_queue_unit.sv @@
// Retransmit packet queue.
// Input channel (in_valid_i / in_stall_o) carries one command per transfer:
// add_start, add_byte, three send modes, acknowledge, clear or read_byte.
// Output channel (out_valid_o / out_stall_i) returns one result per command:
// accepted flag, transmit start and count, read byte, and the queue state
// (empty flag, oldest packet number) after the command.
// One command is in work at a time. The result is loaded in S_FIN, after
// S_LOAD, S_EXEC and S_SETTLE; send_stream on a non-empty queue adds S_CHK,
// plus an S_WAIT and S_CHK per packet it retires, each a read-modify-write of
// the descriptor memory. A new command is taken the cycle after the result is
// loaded, so the block takes no new command before the last one is through.
// The descriptor memory has registered reads, which sets the load and
// settle cycles around each update.
// After reset the block zeroes descriptor slot 0 in S_INIT, with
// in_stall_o high; the byte store is not initialized.
// While out_stall_i holds a result, the next command waits in its final
// cycle and in_stall_o stays high.
module retransmit_packet_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] packet_size_i,
  input  logic [15:0] packet_number_i,
  input  logic [7:0]  packet_flags_i,
  input  logic [12:0] link_space_i,
  input  logic [11:0] read_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [11:0] tx_start_o,
  output logic [12:0] tx_count_o,
  output logic [7:0]  read_data_o,
  output logic        queue_empty_o,
  output logic [15:0] oldest_number_o
);

  rpq_pkg::cmd_t cmd;
  rpq_pkg::sts_t sts;

  rpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  rpq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .data_byte_i     (data_byte_i),
    .packet_size_i   (packet_size_i),
    .packet_number_i (packet_number_i),
    .packet_flags_i  (packet_flags_i),
    .link_space_i    (link_space_i),
    .read_address_i  (read_address_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .accepted_o      (accepted_o),
    .tx_start_o      (tx_start_o),
    .tx_count_o      (tx_count_o),
    .read_data_o     (read_data_o),
    .queue_empty_o   (queue_empty_o),
    .oldest_number_o (oldest_number_o)
  );

endmodule

@@ tb/tb_retransmit_packet_queue_unit.sv @@
`timescale 1ns / 1ps

module tb_retransmit_packet_queue_unit;

  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic        acc;
    logic [11:0] start;
    logic [12:0] count;
    logic [7:0]  rdata;
    logic        empty;
    logic [15:0] oldest;
  } txn_result_t;

  class rpq_scoreboard;
    int pos[rpq_pkg::MAX_PACKETS];
    int num[rpq_pkg::MAX_PACKETS];
    int sz[rpq_pkg::MAX_PACKETS];
    int flg[rpq_pkg::MAX_PACKETS];
    int oldest, newest, rc, fptr, frem;
    logic [7:0] mem[rpq_pkg::BUFFER_BYTES];
    bit written[rpq_pkg::BUFFER_BYTES];
    txn_result_t pending[$];
    int errors;

    function void wipe_ring();
      for (int i = 0; i < rpq_pkg::MAX_PACKETS; i++) begin
        pos[i] = 0; num[i] = 0; sz[i] = 0; flg[i] = 0;
      end
      oldest = 0; newest = 0; rc = 0; frem = 0;
    endfunction

    function bit has_data();
      return sz[oldest] > 0;
    endfunction

    function void retire();
      pos[oldest] = 0; num[oldest] = 0; sz[oldest] = 0; flg[oldest] = 0;
      if (oldest != newest) oldest = (oldest + 1) % rpq_pkg::MAX_PACKETS;
      rc = 0;
    endfunction

    function void note(rpq_pkg::op_e op, logic [7:0] db, logic [11:0] ps,
                       logic [15:0] pn, logic [7:0] pf, logic [12:0] sp,
                       logic [11:0] ra);
      txn_result_t r;
      int start, room, total, sent, left, o;
      bit ne, full, single, go;
      r = '0;
      o = oldest;
      case (op)
        rpq_pkg::OP_ADD_START: begin
          start = (pos[newest] + sz[newest]) % rpq_pkg::BUFFER_BYTES;
          room = (pos[o] + rpq_pkg::BUFFER_BYTES - start) % rpq_pkg::BUFFER_BYTES;
          ne = has_data();
          full = ne && ((newest + 1) % rpq_pkg::MAX_PACKETS) == oldest;
          if (ps != 0 && !full && (!ne || room >= ps)) begin
            if (ne) newest = (newest + 1) % rpq_pkg::MAX_PACKETS;
            pos[newest] = start; num[newest] = pn; sz[newest] = ps; flg[newest] = pf;
            fptr = start; frem = ps;
            r.acc = 1'b1;
          end
        end
        rpq_pkg::OP_ADD_BYTE: begin
          if (frem > 0) begin
            mem[fptr] = db; written[fptr] = 1'b1;
            fptr = (fptr + 1) % rpq_pkg::BUFFER_BYTES;
            frem--;
          end
        end
        rpq_pkg::OP_SEND_STREAM: begin
          if (has_data()) begin
            total = (pos[newest] + rpq_pkg::BUFFER_BYTES - pos[o]) % rpq_pkg::BUFFER_BYTES
                    + sz[newest];
            sent = (sp < total) ? sp : total;
            left = sent;
            r.start = 12'(pos[o]); r.count = 13'(sent); r.acc = sent > 0;
            while (left > 0 && sz[oldest] > 0 && sz[oldest] <= left) begin
              left -= sz[oldest];
              retire();
            end
            if (left > 0) begin
              sz[oldest] -= left;
              pos[oldest] = (pos[oldest] + left) % rpq_pkg::BUFFER_BYTES;
              flg[oldest] |= rpq_pkg::FLAG_MODIFIED;
            end
          end
        end
        rpq_pkg::OP_SEND_OLDEST: begin
          if (has_data() && sp >= sz[o]) begin
            r.acc = 1'b1; r.start = 12'(pos[o]); r.count = 13'(sz[o]);
            retire();
          end
        end
        rpq_pkg::OP_SEND_RESEND: begin
          single = (flg[o] & rpq_pkg::FLAG_SINGLE) != 0;
          go = has_data() && (rc == 0 || single) && sp >= sz[o];
          rc = (rc + 1) % rpq_pkg::RESEND_PERIOD;
          if (go) begin
            r.acc = 1'b1; r.start = 12'(pos[o]); r.count = 13'(sz[o]);
            if (single) retire();
          end
        end
        rpq_pkg::OP_ACK: if (num[o] == pn) retire();
        rpq_pkg::OP_CLEAR: wipe_ring();
        default: r.rdata = mem[ra];
      endcase
      r.empty = !has_data();
      r.oldest = 16'(num[oldest]);
      pending.push_back(r);
    endfunction

    function void check(txn_result_t a);
      txn_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", a);
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] operation_i = '0;
  logic [7:0] data_byte_i = '0;
  logic [11:0] packet_size_i = '0;
  logic [15:0] packet_number_i = '0;
  logic [7:0] packet_flags_i = '0;
  logic [12:0] link_space_i = '0;
  logic [11:0] read_address_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic accepted_o;
  logic [11:0] tx_start_o;
  logic [12:0] tx_count_o;
  logic [7:0] read_data_o;
  logic queue_empty_o;
  logic [15:0] oldest_number_o;

  rpq_scoreboard sb = new();
  int cycles = 0;
  int rx_wait = 0;
  bit no_idle = 1'b0;

  retransmit_packet_queue_unit uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      sb.check({accepted_o, tx_start_o, tx_count_o, read_data_o, queue_empty_o,
                oldest_number_o});
      rx_wait = no_idle ? 0 : $urandom_range(0, 3);
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = rx_wait > 0;
    if (rx_wait > 0) rx_wait--;
  end

  task automatic drive(rpq_pkg::op_e op, logic [7:0] db = '0, logic [11:0] ps = '0,
                       logic [15:0] pn = '0, logic [7:0] pf = '0,
                       logic [12:0] sp = '0, logic [11:0] ra = '0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op; data_byte_i = db; packet_size_i = ps;
    packet_number_i = pn; packet_flags_i = pf; link_space_i = sp; read_address_i = ra;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(op, db, ps, pn, pf, sp, ra);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_item();
    int w;
    logic [11:0] ra;
    logic [12:0] sp;
    logic [15:0] pn;
    w = $urandom_range(0, 99);
    sp = ($urandom_range(0, 9) == 0) ? 13'(4096) : 13'($urandom_range(0, 4095));
    if ($urandom_range(0, 1)) sp = 13'($urandom_range(0, 40));
    if (w < 14) begin
      drive(rpq_pkg::OP_ADD_START, '0,
            ($urandom_range(0, 40) == 0) ? 12'($urandom) : 12'($urandom_range(0, 24)),
            16'($urandom), 8'($urandom));
    end else if (w < 50 && sb.frem > 0) begin
      drive(rpq_pkg::OP_ADD_BYTE, 8'($urandom));
    end else if (w < 58) begin
      drive(rpq_pkg::OP_SEND_STREAM, '0, '0, '0, '0, sp);
    end else if (w < 66) begin
      drive(rpq_pkg::OP_SEND_OLDEST, '0, '0, '0, '0, sp);
    end else if (w < 76) begin
      drive(rpq_pkg::OP_SEND_RESEND, '0, '0, '0, '0, sp);
    end else if (w < 86) begin
      pn = $urandom_range(0, 3) ? 16'(sb.num[sb.oldest]) : 16'($urandom);
      drive(rpq_pkg::OP_ACK, '0, '0, pn);
    end else if (w < 88) begin
      drive(rpq_pkg::OP_CLEAR);
    end else begin
      ra = 12'($urandom);
      for (int k = 0; k < 64 && !sb.written[ra]; k++) ra = 12'($urandom);
      if (sb.written[ra]) drive(rpq_pkg::OP_READ_BYTE, '0, '0, '0, '0, '0, ra);
      else drive(rpq_pkg::OP_ADD_BYTE, 8'($urandom));
    end
  endtask

  initial begin
    sb.wipe_ring();
    sb.fptr = 0;
    sb.errors = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    drive(rpq_pkg::OP_ADD_START, '0, 12'd0, 16'h1111);
    drive(rpq_pkg::OP_ADD_BYTE, 8'h5a);
    drive(rpq_pkg::OP_ADD_START, '0, 12'd4, 16'hffff, 8'h01);
    drive(rpq_pkg::OP_ADD_BYTE, 8'h00);
    drive(rpq_pkg::OP_ADD_BYTE, 8'hff);
    drive(rpq_pkg::OP_ADD_BYTE, 8'ha5);
    drive(rpq_pkg::OP_ADD_BYTE, 8'h5a);
    drive(rpq_pkg::OP_READ_BYTE, '0, '0, '0, '0, '0, 12'd1);
    drive(rpq_pkg::OP_ADD_START, '0, 12'hfff, 16'h0002, 8'hfe);
    drive(rpq_pkg::OP_ADD_START, '0, 12'd3, 16'h0003, 8'h00);
    drive(rpq_pkg::OP_SEND_RESEND, '0, '0, '0, '0, 13'd4096);
    drive(rpq_pkg::OP_SEND_STREAM, '0, '0, '0, '0, 13'd2);
    drive(rpq_pkg::OP_SEND_OLDEST, '0, '0, '0, '0, 13'd0);
    drive(rpq_pkg::OP_ACK, '0, '0, 16'h1234);
    drive(rpq_pkg::OP_ACK, '0, '0, 16'h0003);
    drive(rpq_pkg::OP_ACK, '0, '0, 16'h0000);
    drive(rpq_pkg::OP_SEND_STREAM, '0, '0, '0, '0, 13'h1fff & 13'd4096);
    drive(rpq_pkg::OP_SEND_OLDEST, '0, '0, '0, '0, 13'd4096);
    drive(rpq_pkg::OP_ADD_START, '0, 12'hfff, 16'h0004, 8'h80);
    drive(rpq_pkg::OP_ADD_START, '0, 12'd1, 16'h0005);
    drive(rpq_pkg::OP_ADD_START, '0, 12'd1, 16'h0006);
    drive(rpq_pkg::OP_SEND_STREAM, '0, '0, '0, '0, 13'd4095);
    drive(rpq_pkg::OP_CLEAR);
    drive(rpq_pkg::OP_ADD_BYTE, 8'h33);

    no_idle = 1'b1;
    for (int i = 0; i <= rpq_pkg::MAX_PACKETS; i++) begin
      drive(rpq_pkg::OP_ADD_START, '0, 12'd1, 16'(i));
    end
    drive(rpq_pkg::OP_SEND_STREAM, '0, '0, '0, '0, 13'd4096);
    drive(rpq_pkg::OP_CLEAR);
    no_idle = 1'b0;
    drain();

    for (int i = 0; i < 550; i++) begin
      if (i % 200 == 100) no_idle = !no_idle;
      if (i == 275) drain();
      random_item();
    end
    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/rpq_pkg.sv
sv/rpq_ctrl.sv
sv/rpq_dp.sv
sv/retransmit_packet_queue_unit.sv
tb/tb_retransmit_packet_queue_unit.sv
